### hw/rtl/pss_pkg.sv
// shared constants, codes and types of the persistent spread sketch
`default_nettype none

package pss_pkg;

    // sketch geometry (columns and bitmap size are powers of two)
    localparam int ROWS        = 4;
    localparam int COLUMNS     = 1024;
    localparam int BITMAP_BITS = 4096;

    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int BIT_W      = $clog2(BITMAP_BITS);
    localparam int CELL_DEPTH = (1 << ROW_W) * COLUMNS;
    localparam int CELL_W     = ROW_W + COL_W;
    localparam int CLR_DEPTH  = (CELL_DEPTH > BITMAP_BITS) ? CELL_DEPTH : BITMAP_BITS;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    // bits_remaining counter and increment divider
    localparam int BR_W   = BIT_W + 1;
    localparam int DVD_W  = BIT_W + 17;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(BITMAP_BITS) << 16;

    // configuration port
    localparam int SEED_W     = 14;
    localparam int SEEDS_W    = 56;
    localparam int THR_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 56;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAIR_SEED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_SEEDS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd2;

    // stream widths
    localparam int IN_W  = 96;
    localparam int OUT_W = 16;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAN  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_OLD      = 3'd0;
    localparam logic [2:0] STAT_UPDATED  = 3'd1;
    localparam logic [2:0] STAT_FILLED   = 3'd2;
    localparam logic [2:0] STAT_REPLACED = 3'd3;
    localparam logic [2:0] STAT_REFUSED  = 3'd4;
    localparam logic [2:0] STAT_QUERY    = 3'd5;

    // hash constants
    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_ADD = 32'he6546b64;
    localparam logic [31:0] MM_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

    // one sketch cell
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] card;
        logic [7:0]  period;
        logic [7:0]  weight;
    } cell_t;

endpackage

`default_nettype wire

### hw/rtl/pss_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/persistent_spread_sketch.sv
// persistent spread sketch top level with its sequencer and shared multiplier
`default_nettype none

// Persistent spread sketch. Each item is an insert, a clean or a query and gives
// exactly one result item. All hashing and the replacement test run through one
// 32x32 multiplier under a sequencer, and the increment comes from a one bit per
// cycle divider, so the block takes one item at a time: an insert whose bitmap
// bit was already set stops after the pair hash and bitmap read, a fresh insert
// goes on through the divider, a row hash and cell read per row and, if needed,
// the replacement test, a query runs at most the row hashes and cell reads, and
// a clean runs a clearing pass over the bitmap. After reset the block runs a
// clearing pass over the cell store and bitmap before it accepts its first
// item; configuration writes are taken at any time.
module persistent_spread_sketch
    import pss_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // opcode[1:0], flow_key[33:2], element[65:34], period[73:66],
    // random_fraction[89:74], zero pad
    input  wire logic [IN_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[2:0], persistence_count[11:3], zero pad
    output logic      [OUT_W-1:0]      m_tdata
);

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_CLEAR    = 19'h00002,
        ST_H_M1     = 19'h00004,
        ST_H_M2     = 19'h00008,
        ST_H_MIX    = 19'h00010,
        ST_H_F1     = 19'h00020,
        ST_H_F2     = 19'h00040,
        ST_H_F3     = 19'h00080,
        ST_BIT_RD   = 19'h00100,
        ST_BIT_CHK  = 19'h00200,
        ST_DIV      = 19'h00400,
        ST_CELL_RD  = 19'h00800,
        ST_CELL_CHK = 19'h01000,
        ST_DECIDE   = 19'h02000,
        ST_MUL_LO   = 19'h04000,
        ST_MUL_HI   = 19'h08000,
        ST_SUM      = 19'h10000,
        ST_CMP      = 19'h20000,
        ST_RESULT   = 19'h40000
    } state_t;

    // row seed out of the packed seed register
    function automatic logic [31:0] row_seed(input logic [SEEDS_W-1:0] seeds,
                                             input logic [ROW_W-1:0] r);
        logic [SEEDS_W-1:0] sh;
        sh = seeds >> (SEED_W * int'(r));
        return 32'(sh[SEED_W-1:0]);
    endfunction

    state_t state_reg, state_next;

    logic [SEED_W-1:0]  pair_seed_reg;
    logic [SEEDS_W-1:0] hash_seeds_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [31:0] elem_reg;
    logic [7:0]  per_reg;
    logic [15:0] rnd_reg;

    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_cells_reg, clr_cells_next;

    logic [31:0] h_reg, h_next;
    logic        word_idx_reg, word_idx_next;
    logic        hash_pair_reg, hash_pair_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;

    logic [BR_W-1:0]   bits_rem_reg, bits_rem_next;
    logic [BR_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [BR_W-1:0]   divisor_reg, divisor_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [31:0]       inc_reg, inc_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CELL_W-1:0] cell_addr_reg, cell_addr_next;
    logic              empty_found_reg, empty_found_next;
    logic [CELL_W-1:0] empty_addr_reg, empty_addr_next;
    logic              min_found_reg, min_found_next;
    logic [CELL_W-1:0] min_addr_reg, min_addr_next;
    logic [31:0]       min_card_reg, min_card_next;
    logic [7:0]        min_period_reg, min_period_next;
    logic [7:0]        min_weight_reg, min_weight_next;

    logic [47:0] a_reg, a_next;
    logic [48:0] sum_reg, sum_next;
    logic [47:0] plo_reg, plo_next;
    logic [65:0] total_reg, total_next;

    logic [2:0] status_reg, status_next;
    logic [8:0] count_reg, count_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [2:0] m_status_reg, m_status_next;
    logic [8:0] m_count_reg, m_count_next;

    logic              bm_we, bm_wdata, bm_rdata;
    logic [BIT_W-1:0]  bm_waddr, bm_raddr;
    logic              cl_we;
    logic [CELL_W-1:0] cl_waddr, cl_raddr;
    cell_t             cl_wdata, cl_rdata;

    // combinational helpers
    logic [31:0] cur_word, t0, t1;
    logic [BR_W:0] trial;
    logic [32:0] card_sum;
    logic [8:0]  dt;
    logic [4:0]  dt_sh, wt_sh;
    logic [47:0] a_val, b_val;
    logic        counts;
    cell_t       fill;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_count_reg, m_status_reg});
    assign cur_word = word_idx_reg ? elem_reg : key_reg;
    assign counts   = (cl_rdata.card >= {thr_reg, 16'h0000});

    // fill value for an empty or replaced cell
    always_comb begin
        fill.key    = key_reg;
        fill.card   = inc_reg;
        fill.period = per_reg;
        fill.weight = 8'd0;
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_cells_next   = clr_cells_reg;
        h_next           = h_reg;
        word_idx_next    = word_idx_reg;
        hash_pair_next   = hash_pair_reg;
        bits_rem_next    = bits_rem_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        divisor_next     = divisor_reg;
        div_cnt_next     = div_cnt_reg;
        inc_next         = inc_reg;
        row_next         = row_reg;
        cell_addr_next   = cell_addr_reg;
        empty_found_next = empty_found_reg;
        empty_addr_next  = empty_addr_reg;
        min_found_next   = min_found_reg;
        min_addr_next    = min_addr_reg;
        min_card_next    = min_card_reg;
        min_period_next  = min_period_reg;
        min_weight_next  = min_weight_reg;
        a_next           = a_reg;
        sum_next         = sum_reg;
        plo_next         = plo_reg;
        total_next       = total_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        mul_a            = 32'd0;
        mul_b            = 32'd0;
        bm_we            = 1'b0;
        bm_waddr         = h_reg[BIT_W-1:0];
        bm_wdata         = 1'b1;
        bm_raddr         = h_reg[BIT_W-1:0];
        cl_we            = 1'b0;
        cl_waddr         = cell_addr_reg;
        cl_wdata         = fill;
        cl_raddr         = {row_reg, h_reg[COL_W-1:0]};
        t0               = 32'd0;
        t1               = 32'd0;
        trial            = '0;
        card_sum         = '0;
        dt               = '0;
        dt_sh            = '0;
        wt_sh            = '0;
        a_val            = '0;
        b_val            = '0;

        unique case (state_reg)
            // take a new item
            ST_IDLE: begin
                if (s_tvalid) begin
                    status_next      = STAT_OLD;
                    count_next       = 9'd0;
                    word_idx_next    = 1'b0;
                    row_next         = '0;
                    empty_found_next = 1'b0;
                    min_found_next   = 1'b0;
                    unique case (s_tdata[1:0])
                        OP_INSERT: begin
                            h_next         = 32'(pair_seed_reg);
                            hash_pair_next = 1'b1;
                            state_next     = ST_H_M1;
                        end
                        OP_CLEAN: begin
                            clr_cnt_next   = '0;
                            clr_cells_next = 1'b0;
                            state_next     = ST_CLEAR;
                        end
                        OP_QUERY: begin
                            status_next    = STAT_QUERY;
                            h_next         = row_seed(hash_seeds_reg, '0);
                            hash_pair_next = 1'b0;
                            state_next     = (s_tdata[33:2] == 32'd0) ? ST_RESULT : ST_H_M1;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            // clearing pass over bitmap, and over cells after reset
            ST_CLEAR: begin
                bm_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(BITMAP_BITS));
                bm_waddr = clr_cnt_reg[BIT_W-1:0];
                bm_wdata = 1'b0;
                cl_we    = clr_cells_reg && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(CELL_DEPTH));
                cl_waddr = clr_cnt_reg[CELL_W-1:0];
                cl_wdata = '0;
                if (clr_cnt_reg == (clr_cells_reg ? CLR_W'(CLR_DEPTH - 1)
                                                  : CLR_W'(BITMAP_BITS - 1))) begin
                    bits_rem_next = BR_W'(BITMAP_BITS);
                    state_next    = clr_cells_reg ? ST_IDLE : ST_RESULT;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            // hash word: multiply by first constant
            ST_H_M1: begin
                mul_a      = cur_word;
                mul_b      = MM_C1;
                state_next = ST_H_M2;
            end
            // rotate and multiply by second constant
            ST_H_M2: begin
                mul_a      = {prod_reg[16:0], prod_reg[31:17]};
                mul_b      = MM_C2;
                state_next = ST_H_MIX;
            end
            // mix word into hash state
            ST_H_MIX: begin
                t0     = h_reg ^ prod_reg[31:0];
                t1     = {t0[18:0], t0[31:19]};
                h_next = (t1 << 2) + t1 + MM_ADD;
                if (hash_pair_reg && !word_idx_reg) begin
                    word_idx_next = 1'b1;
                    state_next    = ST_H_M1;
                end else begin
                    state_next = ST_H_F1;
                end
            end
            // finalise: length, fold, first multiply
            ST_H_F1: begin
                t0         = h_reg ^ (hash_pair_reg ? 32'd8 : 32'd4);
                mul_a      = t0 ^ (t0 >> 16);
                mul_b      = MM_F1;
                state_next = ST_H_F2;
            end
            ST_H_F2: begin
                t0         = prod_reg[31:0];
                mul_a      = t0 ^ (t0 >> 13);
                mul_b      = MM_F2;
                state_next = ST_H_F3;
            end
            ST_H_F3: begin
                t0         = prod_reg[31:0];
                h_next     = t0 ^ (t0 >> 16);
                state_next = hash_pair_reg ? ST_BIT_RD : ST_CELL_RD;
            end
            // bitmap read
            ST_BIT_RD: begin
                state_next = ST_BIT_CHK;
            end
            // fresh bit sets and starts the increment division
            ST_BIT_CHK: begin
                if (bm_rdata) begin
                    status_next = STAT_OLD;
                    state_next  = ST_RESULT;
                end else begin
                    bm_we         = 1'b1;
                    divisor_next  = (bits_rem_reg == '0) ? BR_W'(1) : bits_rem_reg;
                    bits_rem_next = (bits_rem_reg == '0) ? bits_rem_reg : bits_rem_reg - 1'b1;
                    rem_next      = '0;
                    quo_next      = DIVIDEND;
                    div_cnt_next  = '0;
                    state_next    = ST_DIV;
                end
            end
            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                trial = {rem_reg, quo_reg[DVD_W-1]};
                if (trial >= {1'b0, divisor_reg}) begin
                    rem_next = BR_W'(trial - {1'b0, divisor_reg});
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[BR_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DVD_W - 1)) begin
                    inc_next      = 32'(quo_next);
                    row_next      = '0;
                    h_next        = row_seed(hash_seeds_reg, '0);
                    word_idx_next = 1'b0;
                    hash_pair_next = 1'b0;
                    state_next    = ST_H_M1;
                end
            end
            // cell read of the current row
            ST_CELL_RD: begin
                cell_addr_next = {row_reg, h_reg[COL_W-1:0]};
                state_next     = ST_CELL_CHK;
            end
            // examine the cell of this row
            ST_CELL_CHK: begin
                if (op_reg == OP_QUERY && cl_rdata.key == key_reg) begin
                    count_next = 9'(cl_rdata.weight) + 9'(counts);
                    state_next = ST_RESULT;
                end else if (op_reg != OP_QUERY && cl_rdata.key == 32'd0) begin
                    empty_found_next = 1'b1;
                    empty_addr_next  = cell_addr_reg;
                end else if (op_reg != OP_QUERY && cl_rdata.key == key_reg) begin
                    cl_we = 1'b1;
                    cl_wdata = cl_rdata;
                    if (cl_rdata.period == per_reg) begin
                        card_sum      = {1'b0, cl_rdata.card} + {1'b0, inc_reg};
                        cl_wdata.card = card_sum[32] ? 32'hffffffff : card_sum[31:0];
                    end else begin
                        if (counts && cl_rdata.weight != 8'hff) begin
                            cl_wdata.weight = cl_rdata.weight + 1'b1;
                        end
                        cl_wdata.card   = inc_reg;
                        cl_wdata.period = per_reg;
                    end
                    status_next = STAT_UPDATED;
                    state_next  = ST_RESULT;
                end else if (op_reg != OP_QUERY &&
                             (!min_found_reg || cl_rdata.card < min_card_reg)) begin
                    min_found_next  = 1'b1;
                    min_addr_next   = cell_addr_reg;
                    min_card_next   = cl_rdata.card;
                    min_period_next = cl_rdata.period;
                    min_weight_next = cl_rdata.weight;
                end
                // next row unless finished above
                if (state_next == ST_CELL_CHK) begin
                    if (row_reg == ROW_W'(ROWS - 1)) begin
                        state_next = (op_reg == OP_QUERY) ? ST_RESULT : ST_DECIDE;
                    end else begin
                        row_next      = row_reg + 1'b1;
                        h_next        = row_seed(hash_seeds_reg, row_reg + 1'b1);
                        word_idx_next = 1'b0;
                        state_next    = ST_H_M1;
                    end
                end
            end
            // fill an empty row or set up the replacement test
            ST_DECIDE: begin
                dt = {1'b0, per_reg} - {1'b0, min_period_reg};
                if (empty_found_reg) begin
                    cl_we       = 1'b1;
                    cl_waddr    = empty_addr_reg;
                    status_next = STAT_FILLED;
                    state_next  = ST_RESULT;
                end else if (!min_found_reg || (dt == 9'd0 && min_weight_reg != 8'd0)) begin
                    status_next = STAT_REFUSED;
                    state_next  = ST_RESULT;
                end else begin
                    if (dt[8]) begin
                        dt_sh = 5'd0;
                    end else if (dt > 9'd16) begin
                        dt_sh = 5'd16;
                    end else begin
                        dt_sh = dt[4:0];
                    end
                    wt_sh      = (min_weight_reg > 8'd16) ? 5'd16 : min_weight_reg[4:0];
                    a_val      = {16'h0000, inc_reg} << dt_sh;
                    b_val      = {16'h0000, min_card_reg} << wt_sh;
                    a_next     = a_val;
                    sum_next   = {1'b0, a_val} + {1'b0, b_val};
                    state_next = ST_MUL_LO;
                end
            end
            // random draw times the low word of the sum
            ST_MUL_LO: begin
                mul_a      = sum_reg[31:0];
                mul_b      = 32'(rnd_reg);
                state_next = ST_MUL_HI;
            end
            // random draw times the high part of the sum
            ST_MUL_HI: begin
                plo_next   = prod_reg[47:0];
                mul_a      = 32'(sum_reg[48:32]);
                mul_b      = 32'(rnd_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                total_next = {prod_reg[33:0], 32'h0000_0000} + 66'(plo_reg);
                state_next = ST_CMP;
            end
            // replace when draw * (a + b) <= a << 16
            ST_CMP: begin
                if (total_reg <= {2'b00, a_reg, 16'h0000}) begin
                    cl_we       = 1'b1;
                    cl_waddr    = min_addr_reg;
                    status_next = STAT_REPLACED;
                end else begin
                    status_next = STAT_REFUSED;
                end
                state_next = ST_RESULT;
            end
            // hand the result item to the output register
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_cells_reg  <= 1'b1;
            bits_rem_reg   <= BR_W'(BITMAP_BITS);
            m_tvalid_reg   <= 1'b0;
            pair_seed_reg  <= '0;
            hash_seeds_reg <= '0;
            thr_reg        <= THR_W'(1);
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_cells_reg <= clr_cells_next;
            bits_rem_reg  <= bits_rem_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_PAIR_SEED: pair_seed_reg  <= cfg_wr_data[SEED_W-1:0];
                    CFG_ROW_SEEDS: hash_seeds_reg <= cfg_wr_data[SEEDS_W-1:0];
                    CFG_THRESHOLD: thr_reg        <= cfg_wr_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tdata[1:0];
            key_reg  <= s_tdata[33:2];
            elem_reg <= s_tdata[65:34];
            per_reg  <= s_tdata[73:66];
            rnd_reg  <= s_tdata[89:74];
        end
        prod_reg        <= 64'(mul_a) * 64'(mul_b);
        h_reg           <= h_next;
        word_idx_reg    <= word_idx_next;
        hash_pair_reg   <= hash_pair_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        divisor_reg     <= divisor_next;
        div_cnt_reg     <= div_cnt_next;
        inc_reg         <= inc_next;
        row_reg         <= row_next;
        cell_addr_reg   <= cell_addr_next;
        empty_found_reg <= empty_found_next;
        empty_addr_reg  <= empty_addr_next;
        min_found_reg   <= min_found_next;
        min_addr_reg    <= min_addr_next;
        min_card_reg    <= min_card_next;
        min_period_reg  <= min_period_next;
        min_weight_reg  <= min_weight_next;
        a_reg           <= a_next;
        sum_reg         <= sum_next;
        plo_reg         <= plo_next;
        total_reg       <= total_next;
        status_reg      <= status_next;
        count_reg       <= count_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
    end

    // pair bitmap
    pss_ram #(
        .WIDTH(1),
        .DEPTH(BITMAP_BITS)
    ) u_bitmap (
        .clk   (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // cell store, row in the upper address bits
    pss_ram #(
        .WIDTH($bits(cell_t)),
        .DEPTH(CELL_DEPTH)
    ) u_cells (
        .clk   (aclk),
        .we    (cl_we),
        .waddr (cl_waddr),
        .wdata (cl_wdata),
        .raddr (cl_raddr),
        .rdata (cl_rdata)
    );

`ifndef NO_ASSERTIONS
    // a result item appears only out of the result state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result item without result state");

    // bits remaining never exceed the bitmap size
    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_rem_reg <= BR_W'(BITMAP_BITS))
        else $error("bits remaining out of range");

    // only a query answer carries a nonzero count
    a_count_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_status_reg == STAT_QUERY || m_count_reg == 9'd0))
        else $error("count on a non-query result");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench of the persistent spread sketch: directed and random items
`timescale 1ns / 1ps

module tb_top;
    import pss_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // opcode, flow_key, element, period, random_fraction, zero pad
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // status, persistence_count, zero pad
    logic [OUT_W-1:0]      m_tdata;

    persistent_spread_sketch uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // sketch model state
    logic [13:0] pair_seed;
    logic [55:0] hash_seeds;
    logic [15:0] threshold;
    bit          seen_bit [BITMAP_BITS];
    int unsigned free_bits;
    logic [31:0] m_key [ROWS][COLUMNS];
    logic [31:0] m_card [ROWS][COLUMNS];
    logic [7:0]  m_per [ROWS][COLUMNS];
    logic [7:0]  m_wt [ROWS][COLUMNS];

    logic [11:0] answer_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          rx_idle_on = 1'b1;
    bit          tx_idle_on = 1'b1;
    int          hold_rx = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    logic [31:0] key_pool [8];

    function automatic logic [31:0] rot(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] mix_words(logic [31:0] w0, logic [31:0] w1,
                                               int n, logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        h = seed;
        for (int i = 0; i < n; i++) begin
            k = (i == 0) ? w0 : w1;
            k = k * 32'hcc9e2d51;
            k = rot(k, 15);
            k = k * 32'h1b873593;
            h = h ^ k;
            h = rot(h, 13);
            h = h * 5 + 32'he6546b64;
        end
        h = h ^ (n * 4);
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int col_of(logic [31:0] key, int r);
        return mix_words(key, 32'd0, 1, {18'd0, hash_seeds[14*r +: 14]}) % COLUMNS;
    endfunction

    function automatic bit is_persistent(logic [31:0] card);
        return {32'd0, card} >= ({48'd0, threshold} << 16);
    endfunction

    function automatic void reset_model();
        pair_seed = 0; hash_seeds = 0; threshold = 1; free_bits = BITMAP_BITS;
        foreach (seen_bit[i]) seen_bit[i] = 0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++) begin
                m_key[r][c] = 0; m_card[r][c] = 0; m_per[r][c] = 0; m_wt[r][c] = 0;
            end
    endfunction

    // insert into the model, returns status
    function automatic logic [2:0] sketch_insert(logic [31:0] key, logic [31:0] ele,
                                                 logic [7:0] per, logic [15:0] rnd);
        int bitn, er, ec, mr, mc, c, dt, wt;
        logic [31:0] inc;
        logic [63:0] s, a, b;
        logic [127:0] lhs, rhs;
        er = -1; mr = -1; ec = 0; mc = 0;
        bitn = mix_words(key, ele, 2, {18'd0, pair_seed}) % BITMAP_BITS;
        if (seen_bit[bitn]) return STAT_OLD;
        inc = 32'((64'(BITMAP_BITS) << 16) / ((free_bits != 0) ? 64'(free_bits) : 64'd1));
        if (free_bits != 0) free_bits--;
        seen_bit[bitn] = 1;
        for (int r = 0; r < ROWS; r++) begin
            c = col_of(key, r);
            if (m_key[r][c] == 0) begin
                er = r; ec = c;
            end else if (m_key[r][c] == key) begin
                if (m_per[r][c] == per) begin
                    s = 64'(m_card[r][c]) + 64'(inc);
                    m_card[r][c] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
                end else begin
                    if (is_persistent(m_card[r][c]) && m_wt[r][c] != 8'd255)
                        m_wt[r][c]++;
                    m_card[r][c] = inc;
                    m_per[r][c] = per;
                end
                return STAT_UPDATED;
            end else if (mr < 0 || m_card[r][c] < m_card[mr][mc]) begin
                mr = r; mc = c;
            end
        end
        if (er >= 0) begin
            m_key[er][ec] = key; m_card[er][ec] = inc; m_per[er][ec] = per;
            m_wt[er][ec] = 0;
            return STAT_FILLED;
        end
        dt = int'(per) - int'(m_per[mr][mc]);
        wt = int'(m_wt[mr][mc]);
        if (dt == 0 && wt != 0) return STAT_REFUSED;
        if (dt < 0) dt = 0;
        if (dt > 16) dt = 16;
        if (wt > 16) wt = 16;
        a = 64'(inc) << dt;
        b = 64'(m_card[mr][mc]) << wt;
        lhs = 128'(rnd) * (128'(a) + 128'(b));
        rhs = 128'(a) << 16;
        if (lhs <= rhs) begin
            m_key[mr][mc] = key; m_card[mr][mc] = inc; m_per[mr][mc] = per;
            m_wt[mr][mc] = 0;
            return STAT_REPLACED;
        end
        return STAT_REFUSED;
    endfunction

    function automatic logic [8:0] sketch_query(logic [31:0] key);
        int c;
        if (key == 0) return 0;
        for (int r = 0; r < ROWS; r++) begin
            c = col_of(key, r);
            if (m_key[r][c] == key)
                return 9'(m_wt[r][c]) + (is_persistent(m_card[r][c]) ? 9'd1 : 9'd0);
        end
        return 0;
    endfunction

    // predicted {count, status} of one item
    function automatic logic [11:0] sketch_step(logic [1:0] op, logic [31:0] key,
                                                logic [31:0] ele, logic [7:0] per,
                                                logic [15:0] rnd);
        case (op)
            OP_INSERT: return {9'd0, sketch_insert(key, ele, per, rnd)};
            OP_CLEAN: begin
                foreach (seen_bit[i]) seen_bit[i] = 0;
                free_bits = BITMAP_BITS;
                return {9'd0, STAT_OLD};
            end
            OP_QUERY: return {sketch_query(key), STAT_QUERY};
            default: return {9'd0, STAT_OLD};
        endcase
    endfunction

    task automatic reg_write(logic [CFG_ADDR_W-1:0] idx, logic [55:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PAIR_SEED: pair_seed = val[13:0];
            CFG_ROW_SEEDS: hash_seeds = val;
            CFG_THRESHOLD: threshold = val[15:0];
            default: ;
        endcase
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // offer one item until accepted, with optional idle burst first
    task automatic send_item(logic [1:0] op, logic [31:0] key, logic [31:0] ele,
                             logic [7:0] per, logic [15:0] rnd);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rnd, per, ele, key, op};
        do @(posedge aclk); while (!s_tready);
        answer_q.push_back(sketch_step(op, key, ele, per, rnd));
    endtask

    function automatic logic [31:0] pick_key();
        return key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic test_directed();
        send_item(OP_QUERY, 32'd0, 32'd0, 8'd0, 16'd0);
        send_item(OP_INSERT, 32'd0, 32'd5, 8'd0, 16'd0);
        send_item(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 16'hFFFF);
        send_item(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 16'hFFFF);
        send_item(OP_INSERT, 32'hFFFFFFFF, 32'd1, 8'd255, 16'd0);
        send_item(OP_INSERT, 32'hFFFFFFFF, 32'd2, 8'd0, 16'd0);
        send_item(OP_QUERY, 32'hFFFFFFFF, 32'd0, 8'd0, 16'd0);
        send_item(2'd3, 32'h12345678, 32'h9abcdef0, 8'd7, 16'h55AA);
        send_item(OP_CLEAN, 32'd0, 32'd0, 8'd0, 16'd0);
        send_item(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd1, 16'd0);
        send_item(OP_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF);
        send_item(OP_QUERY, 32'h1, 32'd0, 8'd0, 16'd0);
    endtask

    // random items over a small key pool and small keys, so cells collide and get replaced
    task automatic test_random(int n, bit quiet);
        logic [1:0] op;
        int sel;
        logic [7:0] per;
        per = 0;
        if (quiet) begin
            tx_idle_on = 0; rx_idle_on = 0;
        end
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) per = per + 8'($urandom_range(1, 20));
            else if (sel < 3) per = 8'($urandom);
            sel = $urandom_range(0, 99);
            op = (sel < 70) ? OP_INSERT : (sel < 73) ? OP_CLEAN :
                 (sel < 96) ? OP_QUERY : 2'd3;
            if ($urandom_range(0, 9) == 0)
                send_item(op, $urandom, $urandom, 8'($urandom), 16'($urandom));
            else
                send_item(op, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 400))
                          : pick_key(), 32'($urandom_range(0, 30)) ^
                          (($urandom_range(0, 7) == 0) ? $urandom : 32'd0),
                          per, 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_reqs++;
        for (int i = 0; i < 6; i++)
            send_item(OP_QUERY, pick_key(), 32'd0, 8'd0, 16'd0);
        drain();
        send_item(OP_INSERT, pick_key(), $urandom, 8'd3, 16'($urandom));
    endtask

    // result checking
    always @(posedge aclk) begin
        logic [11:0] exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                errors++;
            end else begin
                exp_v = answer_q.pop_front();
                if (m_tdata[2:0] !== exp_v[2:0]) begin
                    $error("status: expected %0d, actual %0d", exp_v[2:0], m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[11:3] !== exp_v[11:3]) begin
                    $error("persistence_count: expected %0d, actual %0d",
                           exp_v[11:3], m_tdata[11:3]);
                    errors++;
                end
            end
        end
    end

    // receiver readiness with idle bursts and a long hold-off
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_rx <= 300;
            m_tready <= 1'b0;
        end else if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            hold_rx <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake (reset clearing pass and cleans included)
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        reset_model();
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'd1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        reg_write(CFG_THRESHOLD, 56'd1);
        test_directed();
        test_backpressure();
        test_random(200, 0);
        drain();
        // small row seeds all zero: every row uses one column index, more collisions
        reg_write(CFG_PAIR_SEED, 56'd9999);
        reg_write(CFG_ROW_SEEDS, 56'd0);
        reg_write(CFG_THRESHOLD, 56'd0);
        test_random(200, 0);
        drain();
        reg_write(CFG_PAIR_SEED, 56'($urandom_range(0, 9999)));
        reg_write(CFG_ROW_SEEDS, 56'({$urandom, $urandom}));
        reg_write(CFG_THRESHOLD, 56'd65535);
        test_random(150, 0);
        drain();
        reg_write(CFG_PAIR_SEED, 56'd0);
        reg_write(CFG_ROW_SEEDS, 56'hFFFFFFFFFFFFFF);
        reg_write(CFG_THRESHOLD, 56'd2);
        test_random(150, 0);
        test_random(100, 1);
        drain();
        if (errors == 0 && answer_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
